// ----- rtl/core/msi_pkg.sv -----
// Package for the motor start/stop interlock sequencer.
// Holds the step codes and the scan, state and result word types.
// No dependencies.
`default_nettype none

package msi_pkg;

   // Sequence step codes.
   localparam logic [2:0] STEP_STOPPED  = 3'd0;
   localparam logic [2:0] STEP_PRECHECK = 3'd1;
   localparam logic [2:0] STEP_STARTING = 3'd2;
   localparam logic [2:0] STEP_RUNNING  = 3'd3;
   localparam logic [2:0] STEP_STOPPING = 3'd4;
   localparam logic [2:0] STEP_FAULTED  = 3'd5;

   // Width of the start total shown on the result word.
   localparam int TOTAL_WIDTH = 16;
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 32;

   // One scan of buttons and drive status.
   typedef struct packed {
      logic drive_is_running;
      logic drive_has_fault;
      logic drive_is_ready;
      logic estop_healthy;
      logic reset_button;
      logic stop_button;
      logic start_button;
   } scan_type;

   // Result of one scan.
   typedef struct packed {
      logic [TOTAL_WIDTH-1:0] start_total;
      logic                   permissive;
      logic                   trip_now;
      logic                   trip_is_latched;
      logic [2:0]             sequence_step;
      logic                   alarm_lamp;
      logic                   run_lamp;
      logic                   run_command;
   } result_type;

   // Button levels of the previous scan.
   typedef struct packed {
      logic reset_level;
      logic stop_level;
      logic start_level;
   } buttons_type;

endpackage : msi_pkg

`default_nettype wire

// ----- rtl/core/msi_scan.sv -----
// Combinational scan logic: edge detection, trip latch, step sequence, start count.
// Depends on msi_pkg.
`default_nettype none

module msi_scan
   import msi_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  var scan_type                scan,
   input  var logic [2:0]              step_cur,
   input  var logic                    trip_cur,
   input  var logic [COUNT_WIDTH-1:0]  count_cur,
   input  var buttons_type             buttons_cur,
   output logic [2:0]                  step_nxt,
   output logic                        trip_nxt,
   output logic [COUNT_WIDTH-1:0]      count_nxt,
   output buttons_type                 buttons_nxt,
   output result_type                  result
);

   logic                   start_edge;
   logic                   stop_edge;
   logic                   reset_edge;
   logic                   trip;
   logic                   perm;
   logic                   cmd;
   logic                   alarm;
   logic [2:0]             step_mid;
   logic                   trip_mid;
   logic [31:0]            count_ext;

   // Rising edges against the previous scan's levels.
   assign start_edge = scan.start_button & ~buttons_cur.start_level;
   assign stop_edge  = scan.stop_button  & ~buttons_cur.stop_level;
   assign reset_edge = scan.reset_button & ~buttons_cur.reset_level;

   assign buttons_nxt.start_level = scan.start_button;
   assign buttons_nxt.stop_level  = scan.stop_button;
   assign buttons_nxt.reset_level = scan.reset_button;

   assign trip = ~scan.estop_healthy | ~scan.drive_is_ready | scan.drive_has_fault;

   // Trip forces the faulted step; a clean reset edge clears the latch.
   always_comb begin
      step_mid = step_cur;
      trip_mid = trip_cur;
      if (trip) begin
         trip_mid = 1'b1;
         step_mid = STEP_FAULTED;
      end else if (reset_edge) begin
         trip_mid = 1'b0;
         if (step_cur == STEP_FAULTED) begin
            step_mid = STEP_STOPPED;
         end
      end
   end

   assign perm = scan.estop_healthy & scan.drive_is_ready & ~scan.drive_has_fault & ~trip_mid;

   // Step sequence for the step in hand.
   always_comb begin
      step_nxt  = step_mid;
      trip_nxt  = trip_mid;
      count_nxt = count_cur;
      cmd       = 1'b0;
      alarm     = 1'b0;
      unique case (step_mid)
         STEP_STOPPED: begin
            if (start_edge && perm) begin
               step_nxt = STEP_PRECHECK;
            end
         end
         STEP_PRECHECK: begin
            step_nxt = perm ? STEP_STARTING : STEP_FAULTED;
         end
         STEP_STARTING: begin
            cmd = perm & ~stop_edge;
            if (scan.drive_is_running) begin
               if (count_cur != {COUNT_WIDTH{1'b1}}) begin
                  count_nxt = count_cur + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
               end
               step_nxt = STEP_RUNNING;
            end else if (!cmd) begin
               step_nxt = STEP_STOPPED;
            end
         end
         STEP_RUNNING: begin
            cmd = perm & ~stop_edge;
            if (!cmd) begin
               step_nxt = STEP_STOPPING;
            end
         end
         STEP_STOPPING: begin
            if (!scan.drive_is_running) begin
               step_nxt = STEP_STOPPED;
            end
         end
         STEP_FAULTED: begin
            alarm = 1'b1;
         end
         default: begin
            trip_nxt = 1'b1;
            step_nxt = STEP_FAULTED;
         end
      endcase
   end

   // Counter widened so its low bits can be shown at any counter width up to 32 bits.
   always_comb begin
      count_ext = '0;
      count_ext[COUNT_WIDTH-1:0] = count_nxt;
   end

   assign result.run_command     = cmd;
   assign result.run_lamp        = cmd;
   assign result.alarm_lamp      = alarm;
   assign result.sequence_step   = step_nxt;
   assign result.trip_is_latched = trip_nxt;
   assign result.trip_now        = trip;
   assign result.permissive      = perm;
   assign result.start_total     = count_ext[TOTAL_WIDTH-1:0];

endmodule : msi_scan

`default_nettype wire

// ----- rtl/core/motor_start_stop_interlock_sequencer.sv -----
// Motor start/stop interlock sequencer with trip latch, top level.
// An accepted request word is held in the input register, then passes
// through the scan logic into the response register.
// Throughput: one word per cycle; each stage advances when the next is free.
// Reset (synchronous, active high) empties both stages, sets the step to
// stopped and clears the trip latch, the start count and the button history.
// Depends on msi_pkg and msi_scan.
`default_nettype none

module motor_start_stop_interlock_sequencer
   import msi_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  var logic                       clock,
   input  var logic                       reset,
   input  var logic                       req_tvalid,
   output logic                           req_tready,
   // Fields from bit 0: start_button, stop_button, reset_button, estop_healthy,
   // drive_is_ready, drive_has_fault, drive_is_running, one unused bit.
   input  var logic [REQ_DATA_WIDTH-1:0]  req_tdata,
   output logic                           rsp_tvalid,
   input  var logic                       rsp_tready,
   // Fields from bit 0: run_command, run_lamp, alarm_lamp, sequence_step[2:0],
   // trip_is_latched, trip_now, permissive, start_total[15:0], seven zero pad bits.
   output logic [RSP_DATA_WIDTH-1:0]      rsp_tdata
);

   localparam int ScanBits = $bits(scan_type);
   localparam int ResultBits = $bits(result_type);

   logic                    in_vld_ff,  in_vld_in;
   scan_type                in_scan_ff, in_scan_in;
   logic                    out_vld_ff, out_vld_in;
   result_type              out_res_ff, out_res_in;
   logic [2:0]              step_ff,    step_in;
   logic                    trip_ff,    trip_in;
   logic [COUNT_WIDTH-1:0]  count_ff,   count_in;
   buttons_type             buttons_ff, buttons_in;

   logic                    out_free;
   logic                    advance;
   logic                    req_take;
   result_type              scan_res;

   // Stage flow control.
   assign out_free   = ~out_vld_ff | rsp_tready;
   assign advance    = in_vld_ff & out_free;
   assign req_tready = ~in_vld_ff | advance;
   assign req_take   = req_tvalid & req_tready;

   msi_scan #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_scan (
      .scan        (in_scan_ff),
      .step_cur    (step_ff),
      .trip_cur    (trip_ff),
      .count_cur   (count_ff),
      .buttons_cur (buttons_ff),
      .step_nxt    (step_in),
      .trip_nxt    (trip_in),
      .count_nxt   (count_in),
      .buttons_nxt (buttons_in),
      .result      (scan_res)
   );

   // Next values of the pipeline stages.
   always_comb begin
      in_vld_in  = req_take | (in_vld_ff & ~advance);
      in_scan_in = req_take ? req_tdata[ScanBits-1:0] : in_scan_ff;
      out_vld_in = advance | (out_vld_ff & ~rsp_tready);
      out_res_in = advance ? scan_res : out_res_ff;
   end

   // Control and sequence state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         step_ff    <= STEP_STOPPED;
         trip_ff    <= 1'b0;
         count_ff   <= '0;
         buttons_ff <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (advance) begin
            step_ff    <= step_in;
            trip_ff    <= trip_in;
            count_ff   <= count_in;
            buttons_ff <= buttons_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_scan_ff <= in_scan_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH-ResultBits){1'b0}}, out_res_ff};

`ifndef SYNTH
   // The held step never takes an unused code.
   a_step_legal: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_FAULTED)
      else $error("sequencer step holds an unused code");

   // A trip in a scan leaves the latch set and the step faulted.
   a_trip_faults: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (!out_res_ff.trip_now ||
         (out_res_ff.trip_is_latched && out_res_ff.sequence_step == STEP_FAULTED)))
      else $error("trip did not latch or fault the sequence");

   // The drive is never commanded to run while the alarm shows.
   a_cmd_no_alarm: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> !(out_res_ff.run_command && out_res_ff.alarm_lamp))
      else $error("run command together with alarm");

   // Permissive excludes a latched trip.
   a_perm_clean: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> !(out_res_ff.permissive && out_res_ff.trip_is_latched))
      else $error("permissive with latched trip");

   // Sequence state only moves when a word passes into the response stage.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(step_ff) && $stable(trip_ff) && $stable(count_ff))
      else $error("sequence state changed without a word");
`endif

endmodule : motor_start_stop_interlock_sequencer

`default_nettype wire
